### design/lmfs_pkg.sv
// ----------------------------------------------------------------------------
// LED matrix scanner package
// Shared types, microcode format and constant tables for the scanner.
// ----------------------------------------------------------------------------
package lmfs_pkg;

   localparam int STEP_W  = 3;
   localparam int FRAME_W = 64;

   typedef logic [STEP_W-1:0] step_type;

   typedef enum logic [1:0] {
      REQ_WRITE  = 2'd0,
      REQ_CLEAR  = 2'd1,
      REQ_UPDATE = 2'd2,
      REQ_INIT   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      COND_ALWAYS    = 2'd0,
      COND_DISPATCH  = 2'd1,
      COND_LOOP_SCAN = 2'd2,
      COND_LOOP_INIT = 2'd3
   } cond_type;

   // program addresses
   localparam step_type STEP_DISPATCH  = 3'd0;
   localparam step_type STEP_SCAN      = 3'd1;
   localparam step_type STEP_SCAN_DONE = 3'd2;
   localparam step_type STEP_INIT      = 3'd3;
   localparam step_type STEP_INIT_DONE = 3'd4;

   typedef struct packed {
      logic     accept;
      logic     emit_scan;
      logic     emit_init;
      cond_type cond;
      step_type target;
   } ucode_type;

   typedef struct packed {
      logic write_pixel;
      logic clear_store;
      logic emit_scan;
      logic emit_init;
   } ctrl_type;

   typedef struct packed {
      logic out_busy;
      logic scan_end;
      logic init_end;
   } status_type;

   localparam logic [3:0] FRAME_BYTES_SCAN = 4'd8;
   localparam logic [3:0] FRAME_BYTES_INIT = 4'd2;
   localparam logic [3:0] INIT_LAST_STEP   = 4'd8;

   function automatic logic [7:0] init_addr(input logic [3:0] step);
      logic [7:0] a;
      case (step)
         4'd0:    a = 8'h09;
         4'd1:    a = 8'h0A;
         4'd2:    a = 8'h0B;
         4'd3:    a = 8'h0C;
         4'd4:    a = 8'h0F;
         default: a = 8'h00;
      endcase
      return a;
   endfunction

   function automatic logic [7:0] init_data(input logic [3:0] step, input logic [3:0] level);
      logic [7:0] d;
      case (step)
         4'd1:    d = {4'd0, level};
         4'd2:    d = 8'h07;
         4'd3:    d = 8'h01;
         default: d = 8'h00;
      endcase
      return d;
   endfunction

endpackage

### design/lmfs_ucode_rom.sv
// ----------------------------------------------------------------------------
// Microcode ROM
// Control word for each step of the scanner program.
// ----------------------------------------------------------------------------
module lmfs_ucode_rom (
   input  lmfs_pkg::step_type  step,
   output lmfs_pkg::ucode_type word
);
   import lmfs_pkg::*;

   always_comb begin
      word = '{accept: 1'b0, emit_scan: 1'b0, emit_init: 1'b0,
               cond: COND_ALWAYS, target: STEP_DISPATCH};
      case (step)
         STEP_DISPATCH: begin
            word.accept = 1'b1;
            word.cond   = COND_DISPATCH;
            word.target = STEP_DISPATCH;
         end
         STEP_SCAN: begin
            word.emit_scan = 1'b1;
            word.cond      = COND_LOOP_SCAN;
            word.target    = STEP_SCAN;
         end
         STEP_INIT: begin
            word.emit_init = 1'b1;
            word.cond      = COND_LOOP_INIT;
            word.target    = STEP_INIT;
         end
         STEP_SCAN_DONE, STEP_INIT_DONE: begin
            word.cond   = COND_ALWAYS;
            word.target = STEP_DISPATCH;
         end
         default: begin
            word.cond   = COND_ALWAYS;
            word.target = STEP_DISPATCH;
         end
      endcase
   end

endmodule

### design/lmfs_sequencer.sv
// ----------------------------------------------------------------------------
// Microcode sequencer
// Step counter with conditional jumps; decodes control words for the datapath.
// ----------------------------------------------------------------------------
module lmfs_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_type,
   input  lmfs_pkg::status_type status,
   output logic                 req_ready,
   output lmfs_pkg::ctrl_type   ctrl
);
   import lmfs_pkg::*;

   step_type     step_ff;
   step_type     step_in;
   ucode_type    word;
   logic         hold;
   logic         accepted;
   req_kind_type kind;

   lmfs_ucode_rom u_rom (
      .step (step_ff),
      .word (word)
   );

   assign kind      = req_kind_type'(req_type);
   assign hold      = (word.emit_scan | word.emit_init) & status.out_busy;
   assign req_ready = word.accept;
   assign accepted  = req_valid & word.accept;

   always_comb begin
      ctrl.write_pixel = accepted && (kind == REQ_WRITE);
      ctrl.clear_store = accepted && (kind == REQ_CLEAR);
      ctrl.emit_scan   = word.emit_scan & ~hold;
      ctrl.emit_init   = word.emit_init & ~hold;
   end

   always_comb begin
      step_in = step_ff;
      if (!hold) begin
         case (word.cond)
            COND_ALWAYS:    step_in = word.target;
            COND_DISPATCH: begin
               if (accepted) begin
                  case (kind)
                     REQ_CLEAR, REQ_UPDATE: step_in = STEP_SCAN;
                     REQ_INIT:              step_in = STEP_INIT;
                     default:               step_in = STEP_DISPATCH;
                  endcase
               end
            end
            COND_LOOP_SCAN: step_in = status.scan_end ? step_ff + 3'd1 : word.target;
            COND_LOOP_INIT: step_in = status.init_end ? step_ff + 3'd1 : word.target;
            default:        step_in = STEP_DISPATCH;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_DISPATCH;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

### design/lmfs_datapath.sv
// ----------------------------------------------------------------------------
// Scanner datapath
// Pixel store, walk counters, frame assembly and the result register.
// ----------------------------------------------------------------------------
module lmfs_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  lmfs_pkg::ctrl_type   ctrl,
   input  logic [3:0]           req_pixel_x,
   input  logic [3:0]           req_pixel_y,
   input  logic                 req_pixel_on,
   input  logic                 csr_write_en,
   input  logic [3:0]           csr_write_data,
   output lmfs_pkg::status_type status,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [63:0]          rsp_spi_frame,
   output logic [3:0]           rsp_frame_bytes,
   output logic                 rsp_last
);
   import lmfs_pkg::*;

   logic [15:0]        store_ff [16];
   logic [2:0]         row_ff;
   logic [1:0]         dev_ff;
   logic [3:0]         init_ff;
   logic [3:0]         intensity_ff;
   logic               valid_ff;
   logic [FRAME_W-1:0] frame_ff;
   logic [3:0]         bytes_ff;
   logic               last_ff;

   logic [15:0]        row_bits;
   logic [7:0]         scan_data;
   logic [7:0]         scan_addr;
   logic [FRAME_W-1:0] scan_frame;
   logic               load;

   assign status.out_busy = valid_ff & ~rsp_ready;
   assign status.scan_end = (row_ff == 3'd7) && (dev_ff == 2'd3);
   assign status.init_end = (init_ff == INIT_LAST_STEP);
   assign load            = ctrl.emit_scan | ctrl.emit_init;

   // device origin: first offset 8 when device bit 1 clear, second when bit 0 clear
   assign row_bits  = store_ff[{~dev_ff[1], row_ff}];
   assign scan_data = dev_ff[0] ? row_bits[7:0] : row_bits[15:8];
   assign scan_addr = 8'd8 - {5'd0, row_ff};

   always_comb begin
      scan_frame = '0;
      for (int j = 0; j < 4; j++) begin
         if (dev_ff == 2'(j)) begin
            scan_frame[FRAME_W-1-16*j -: 8] = scan_addr;
            scan_frame[FRAME_W-9-16*j -: 8] = scan_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 16; r++) begin
            store_ff[r] <= '0;
         end
      end else if (ctrl.clear_store) begin
         for (int r = 0; r < 16; r++) begin
            store_ff[r] <= '0;
         end
      end else if (ctrl.write_pixel) begin
         store_ff[req_pixel_x][req_pixel_y] <= req_pixel_on;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         dev_ff       <= '0;
         init_ff      <= '0;
         intensity_ff <= '0;
         valid_ff     <= 1'b0;
      end else begin
         if (csr_write_en) begin
            intensity_ff <= csr_write_data;
         end
         if (ctrl.emit_scan) begin
            dev_ff <= dev_ff + 2'd1;
            if (dev_ff == 2'd3) begin
               row_ff <= row_ff + 3'd1;
            end
         end
         if (ctrl.emit_init) begin
            init_ff <= status.init_end ? 4'd0 : init_ff + 4'd1;
         end
         if (load) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit_scan) begin
         frame_ff <= scan_frame;
         bytes_ff <= FRAME_BYTES_SCAN;
         last_ff  <= status.scan_end;
      end else if (ctrl.emit_init) begin
         frame_ff <= {48'd0, init_addr(init_ff), init_data(init_ff, intensity_ff)};
         bytes_ff <= FRAME_BYTES_INIT;
         last_ff  <= status.init_end;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_spi_frame   = frame_ff;
   assign rsp_frame_bytes = bytes_ff;
   assign rsp_last        = last_ff;

endmodule

### design/led_matrix_framebuffer_scanner.sv
// ----------------------------------------------------------------------------
// LED matrix framebuffer scanner
// An update emits 32 frames, one per cycle while the output is taken, and
// passes two further sequencer steps. An init emits 9 frames. A frame is
// registered and appears in the cycle after its step.
// The rate is set by the sequencer, which issues one frame per step.
// Reset clears the pixel store, the intensity register and the sequencer.
// ----------------------------------------------------------------------------
module led_matrix_framebuffer_scanner (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [3:0]  req_pixel_x,
   input  logic [3:0]  req_pixel_y,
   input  logic        req_pixel_on,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_spi_frame,
   output logic [3:0]  rsp_frame_bytes,
   output logic        rsp_last,
   input  logic        csr_write_en,
   input  logic [3:0]  csr_write_data
);
   import lmfs_pkg::*;

   ctrl_type   ctrl;
   status_type status;

   lmfs_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .status    (status),
      .req_ready (req_ready),
      .ctrl      (ctrl)
   );

   lmfs_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .req_pixel_on    (req_pixel_on),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_spi_frame   (rsp_spi_frame),
      .rsp_frame_bytes (rsp_frame_bytes),
      .rsp_last        (rsp_last)
   );

endmodule
